>>> hw/rtl/eek_pkg.sv
// shared types and constants for the k-nearest-neighbor block
`default_nettype none
package eek_pkg;
   localparam int MAX_POINTS_DEF    = 256;
   localparam int MAX_DIM_DEF       = 32;
   localparam int MAX_NEIGHBORS_DEF = 16;
   localparam int DIST_W  = 38;
   localparam int SQRT_W  = 19;
   localparam int SIM_W   = 20;
   localparam logic [SIM_W-1:0] ONE_Q12 = 20'd4096;

   localparam logic [1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [1:0] CSR_DIMENSION   = 2'd1;
   localparam logic [1:0] CSR_NBR_COUNT   = 2'd2;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic               action;
      logic [7:0]         point_index;
      logic [4:0]         component_index;
      logic signed [15:0] component_value;
   } req_type;

   typedef struct packed {
      logic [3:0]         rank;
      logic [7:0]         neighbor_index;
      logic signed [19:0] similarity;
      logic               last;
      logic               status;
   } rsp_type;

   // one candidate travelling down the cell chain
   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] distance;
      logic [7:0]        index;
   } cand_type;
endpackage
`default_nettype wire

>>> hw/rtl/eek_cell.sv
// one slot of the sorted neighbor list; displaced entries move to the next cell
`default_nettype none
module eek_cell (
   input  wire logic              clock,
   input  wire logic              clear,
   input  wire logic              enable,
   input  wire eek_pkg::cand_type cand_in,
   output eek_pkg::cand_type      cand_out,
   output eek_pkg::cand_type      slot
);
   eek_pkg::cand_type slot_ff, slot_in;
   eek_pkg::cand_type out_ff, out_in;
   logic take;

   // order by distance, then by index, so ties go to the smaller index
   always_comb begin
      take    = cand_in.valid && (!slot_ff.valid ||
                cand_in.distance < slot_ff.distance ||
                (cand_in.distance == slot_ff.distance && cand_in.index < slot_ff.index));
      slot_in = slot_ff;
      out_in  = cand_in;
      if (take) begin
         slot_in = cand_in;
         out_in  = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         slot_ff <= '0;
         out_ff  <= '0;
      end else if (enable) begin
         slot_ff <= slot_in;
         out_ff  <= out_in;
      end else begin
         out_ff.valid <= 1'b0;
      end
   end

   assign cand_out = out_ff;
   assign slot     = slot_ff;
endmodule
`default_nettype wire

>>> hw/rtl/eek_sqrt.sv
// bit-serial integer square root, one result bit per cycle
`default_nettype none
module eek_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [eek_pkg::DIST_W-1:0] value,
   output logic                            done,
   output logic [eek_pkg::SQRT_W-1:0]      root
);
   localparam int W = eek_pkg::DIST_W;
   localparam int R = eek_pkg::SQRT_W;
   localparam int CW = $clog2(R + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  res_ff, res_in;
   logic [W-1:0]  bit_ff, bit_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;

   // classic digit-by-digit root, bit starts at 4^(R-1)
   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = value;
         res_in = '0;
         bit_in = W'(1) << (2 * (R - 1));
         cnt_in = CW'(R);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= res_ff + bit_ff) begin
            rem_in = rem_ff - (res_ff + bit_ff);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = res_ff[R-1:0];
endmodule
`default_nettype wire

>>> hw/rtl/exact_euclidean_knn.sv
// top level: point store, distance accumulator, sorting cell chain, result sequencer
//
//  channel   ports                          direction  handshake
//  request   start, busy, req_item          in         start && !busy
//  result    rsp_valid, rsp_item            out        strobe, one cycle
//  config    csr_we, csr_index, csr_data    in         write enable
//
// a load is written when it is accepted and the next item may follow at once. a query
// reads its row, walks the other points (at most one store read per cycle on one port),
// lets the chain settle, then runs the serial square root once per result. an error
// query passes through the ERR state and then strobes its result. reset is synchronous;
// the store is not cleared. results cannot be stalled.
`default_nettype none
module exact_euclidean_knn #(
   parameter int MAX_POINTS    = eek_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIM       = eek_pkg::MAX_DIM_DEF,
   parameter int MAX_NEIGHBORS = eek_pkg::MAX_NEIGHBORS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire eek_pkg::req_type req_item,
   output logic                  rsp_valid,
   output eek_pkg::rsp_type      rsp_item,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [8:0]       csr_data
);
   localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int KW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int AW = PW + DW;
   localparam int DEPTH = MAX_POINTS * MAX_DIM;
   localparam int DIST_W = eek_pkg::DIST_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ROW   = 7'b0000010,
      ST_WALK  = 7'b0000100,
      ST_DRAIN = 7'b0001000,
      ST_ROOT  = 7'b0010000,
      ST_WAIT  = 7'b0100000,
      ST_ERR   = 7'b1000000
   } state_type;

   // configuration registers
   logic [8:0] point_count_ff;
   logic [5:0] dimension_ff;
   logic [4:0] nbr_count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 9'd256;
         dimension_ff   <= 6'd32;
         nbr_count_ff   <= 5'd8;
      end else if (csr_we) begin
         case (csr_index)
            eek_pkg::CSR_POINT_COUNT: point_count_ff <= csr_data;
            eek_pkg::CSR_DIMENSION:   dimension_ff   <= csr_data[5:0];
            eek_pkg::CSR_NBR_COUNT:   nbr_count_ff   <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // effective sizes
   logic [16:0] n_eff, dim_eff, k_eff;
   always_comb begin
      n_eff   = (17'(point_count_ff) > 17'(MAX_POINTS)) ? 17'(MAX_POINTS)
                                                         : 17'(point_count_ff);
      dim_eff = (17'(dimension_ff) > 17'(MAX_DIM)) ? 17'(MAX_DIM) : 17'(dimension_ff);
      k_eff   = 17'(nbr_count_ff);
   end

   state_type     state_ff, state_in;
   logic [16:0]   row_ff;
   logic [16:0]   j_ff;
   logic [16:0]   c_ff;
   logic [16:0]   cnt_ff;
   logic [15:0]   rowbuf_ff [MAX_DIM];
   logic [DIST_W-1:0] acc_ff;
   logic          rd_ok_ff, rd_ok2_ff;
   logic [16:0]   rd_c_ff, rd_c2_ff;
   logic          rd_last_ff, rd_last2_ff;
   logic [16:0]   rd_j_ff, rd_j2_ff;
   logic          rd_row_ff, rd_row2_ff;
   logic [16:0]   rank_ff;

   // point store, one write and one read per cycle
   logic [15:0]   store_mem [DEPTH];
   logic [15:0]   rd_data_ff;
   logic [15:0]   rd_data2_ff;
   logic          load_go;
   logic [AW-1:0] rd_addr;
   assign load_go = start && !busy && req_item.action == eek_pkg::ACT_LOAD &&
                    17'(req_item.point_index) < 17'(MAX_POINTS) &&
                    17'(req_item.component_index) < 17'(MAX_DIM);
   always_ff @(posedge clock) begin
      if (load_go)
         store_mem[(AW)'(req_item.point_index) * (AW)'(MAX_DIM)
                   + (AW)'(req_item.component_index)] <= req_item.component_value;
      rd_data_ff  <= store_mem[rd_addr];
      rd_data2_ff <= rd_data_ff;
   end

   assign rd_addr = (state_ff == ST_ROW) ? AW'(row_ff * 17'(MAX_DIM) + c_ff)
                                          : AW'(j_ff * 17'(MAX_DIM) + c_ff);

   // candidate into the chain
   eek_pkg::cand_type chain [MAX_NEIGHBORS+1];
   eek_pkg::cand_type slots [MAX_NEIGHBORS];
   eek_pkg::cand_type feed_ff;
   logic clear_chain;
   assign chain[0]    = feed_ff;
   assign clear_chain = (state_ff == ST_IDLE);

   for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
      logic live;
      assign live = 17'(g) < k_eff;
      eek_cell u_cell (
         .clock    (clock),
         .clear    (clear_chain || reset),
         .enable   (live),
         .cand_in  (chain[g]),
         .cand_out (chain[g+1]),
         .slot     (slots[g])
      );
   end

   // square root of the selected entry
   logic        sq_start, sq_done;
   logic [eek_pkg::SQRT_W-1:0] sq_root;
   eek_pkg::cand_type sel;
   assign sel = slots[KW'(rank_ff)];
   eek_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sq_start),
      .value (sel.distance), .done (sq_done), .root (sq_root)
   );

   logic query_go, bad;
   assign query_go = start && !busy && req_item.action == eek_pkg::ACT_QUERY;
   assign bad = k_eff == 17'd0 || k_eff > 17'(MAX_NEIGHBORS) || k_eff >= n_eff ||
                17'(req_item.point_index) >= n_eff;

   // one component difference squared, from the twice-registered store data (rd_data2_ff)
   logic signed [16:0] diff;
   logic signed [33:0] sq;
   assign diff = $signed({rd_data2_ff[15], rd_data2_ff}) -
                 $signed({rowbuf_ff[DW'(rd_c2_ff)][15], rowbuf_ff[DW'(rd_c2_ff)]});
   assign sq = 34'(diff) * 34'(diff);

   // sequencer
   logic walk_issue, walk_end;
   assign walk_end   = (state_ff == ST_WALK) && j_ff >= n_eff;
   assign walk_issue = (state_ff == ST_WALK) && !walk_end && j_ff != row_ff &&
                       c_ff < dim_eff;

   always_comb begin
      state_in = state_ff;
      sq_start = 1'b0;
      case (state_ff)
         ST_IDLE: if (query_go) state_in = bad ? ST_ERR : ST_ROW;
         ST_ROW:  if (c_ff + 17'd1 >= dim_eff || dim_eff == 17'd0) state_in = ST_WALK;
         ST_WALK: if (walk_end) state_in = ST_DRAIN;
         ST_DRAIN: if (cnt_ff == 17'd0) begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            sq_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: if (sq_done)
            state_in = (rank_ff + 17'd1 >= k_eff) ? ST_IDLE : ST_ROOT;
         ST_ERR: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_ok_ff   <= 1'b0;
         rd_ok2_ff  <= 1'b0;
         rd_row_ff  <= 1'b0;
         rd_row2_ff <= 1'b0;
         feed_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         rd_ok_ff   <= walk_issue || (state_ff == ST_ROW && dim_eff != 17'd0);
         rd_row_ff  <= (state_ff == ST_ROW);
         rd_ok2_ff  <= rd_ok_ff;
         rd_row2_ff <= rd_row_ff;
         // zero dimension: candidates with zero distance
         if (state_ff == ST_WALK && !walk_end && j_ff != row_ff && dim_eff == 17'd0) begin
            feed_ff <= eek_pkg::cand_type'{valid: 1'b1, distance: '0, index: 8'(j_ff)};
         end else if (rd_ok2_ff && !rd_row2_ff && rd_last2_ff) begin
            feed_ff <= eek_pkg::cand_type'{valid: 1'b1,
                                           distance: acc_ff + DIST_W'(sq),
                                           index: 8'(rd_j2_ff)};
         end else begin
            feed_ff.valid <= 1'b0;
         end
      end
      rd_c_ff     <= c_ff;
      rd_c2_ff    <= rd_c_ff;
      rd_j_ff     <= j_ff;
      rd_j2_ff    <= rd_j_ff;
      rd_last_ff  <= c_ff + 17'd1 >= dim_eff;
      rd_last2_ff <= rd_last_ff;

      // row buffer fill and distance accumulation
      if (rd_ok2_ff && rd_row2_ff) rowbuf_ff[DW'(rd_c2_ff)] <= rd_data2_ff;
      if (rd_ok2_ff && !rd_row2_ff)
         acc_ff <= (rd_last2_ff) ? '0 : acc_ff + DIST_W'(sq);
      else if (state_ff == ST_ROW)
         acc_ff <= '0;

      // counters
      case (state_ff)
         ST_IDLE: begin
            row_ff  <= 17'(req_item.point_index);
            c_ff    <= '0;
            j_ff    <= '0;
            rank_ff <= '0;
         end
         ST_ROW: begin
            c_ff <= (state_in == ST_WALK) ? '0 : c_ff + 17'd1;
         end
         ST_WALK: begin
            if (walk_end) begin
               cnt_ff <= 17'(MAX_NEIGHBORS) + 17'd4;
            end else if (j_ff == row_ff || dim_eff == 17'd0 || c_ff + 17'd1 >= dim_eff) begin
               j_ff <= j_ff + 17'd1;
               c_ff <= '0;
            end else begin
               c_ff <= c_ff + 17'd1;
            end
         end
         ST_DRAIN: cnt_ff <= cnt_ff - 17'd1;
         ST_WAIT: if (sq_done) rank_ff <= rank_ff + 17'd1;
         default: ;
      endcase
   end

   // result register
   logic        rsp_valid_ff;
   eek_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= (state_ff == ST_ERR) || (state_ff == ST_WAIT && sq_done);
      if (state_ff == ST_ERR) begin
         rsp_ff <= eek_pkg::rsp_type'{rank: 4'd0, neighbor_index: 8'd0,
                                      similarity: 20'sd0, last: 1'b1, status: 1'b1};
      end else begin
         rsp_ff.rank           <= 4'(rank_ff);
         rsp_ff.neighbor_index <= sel.index;
         rsp_ff.similarity     <= eek_pkg::ONE_Q12 - 20'(sq_root);
         rsp_ff.last           <= rank_ff + 17'd1 >= k_eff;
         rsp_ff.status         <= 1'b0;
      end
   end

   assign busy      = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule
`default_nettype wire
